### rtl/core/slmc_pkg.sv
package slmc_pkg;

  localparam logic [2:0] CFG_ACCEL_STEP = 3'd0;
  localparam logic [2:0] CFG_MAX_ANGLE  = 3'd1;
  localparam logic [2:0] CFG_STOP_ANGLE = 3'd2;
  localparam logic [2:0] CFG_MIN_ANGLE  = 3'd3;
  localparam logic [2:0] CFG_SPEED_LOW  = 3'd4;
  localparam logic [2:0] CFG_SPEED_HIGH = 3'd5;

  localparam logic signed [7:0] FULL_SPEED = 8'sd100;

  // floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for 0 <= x < 32768
  localparam logic [12:0] DIV_RECIP    = 13'd5243;
  localparam int          DIV_SHIFT    = 19;
  localparam logic [14:0] DIV_CEIL_ADJ = 15'd99;

  typedef struct packed {
    logic [6:0]        accel_step;
    logic [7:0]        max_angle;
    logic [7:0]        stop_angle;
    logic [7:0]        min_angle;
    logic signed [7:0] speed_low;
    logic signed [7:0] speed_high;
  } slmc_cfg_t;

  typedef struct packed {
    logic signed [7:0] speed;
    logic              at_target;
  } slmc_spd_t;

endpackage

### rtl/core/slew_limited_motor_command.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_target_speed[7:0] signed
// out      output     out_valid / out_ready  out_speed_now[7:0] signed, out_angle[7:0],
//                                            out_at_target
// cfg      input      cfg_we (no wait)       cfg_addr[2:0], cfg_wdata[7:0]
//
// One transfer per cycle sustained while out_ready is held high; a result passes
// through four register stages (input, ramp, product, output).
// Reset is synchronous on rst_n: ramp state to zero, registers to defaults.
// A stalled output backs up the pipeline one stage at a time; in_ready drops
// only when every stage holds an item.
module slew_limited_motor_command
  import slmc_pkg::*;
#(
  parameter int MAX_ACCEL = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] in_target_speed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_speed_now,
  output logic [7:0]        out_angle,
  output logic              out_at_target,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [7:0]        cfg_wdata
);

  slmc_cfg_t         cfg_r;
  logic              in_vld_r;
  logic signed [7:0] tgt_r;
  logic              rmp_ready;
  logic              rmp_valid;
  slmc_spd_t         rmp_data;
  logic              map_ready;
  logic              accel_ok;

  assign in_ready = !in_vld_r || rmp_ready;
  assign accel_ok = (cfg_wdata[6:0] != 7'd0) && (cfg_wdata[6:0] <= 7'(MAX_ACCEL));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step <= 7'd1;
      cfg_r.max_angle  <= 8'd180;
      cfg_r.stop_angle <= 8'd90;
      cfg_r.min_angle  <= 8'd6;
      cfg_r.speed_low  <= -FULL_SPEED;
      cfg_r.speed_high <= FULL_SPEED;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ACCEL_STEP: begin
          if (accel_ok) begin
            cfg_r.accel_step <= cfg_wdata[6:0];
          end
        end
        CFG_MAX_ANGLE:  cfg_r.max_angle  <= cfg_wdata;
        CFG_STOP_ANGLE: cfg_r.stop_angle <= cfg_wdata;
        CFG_MIN_ANGLE:  cfg_r.min_angle  <= cfg_wdata;
        CFG_SPEED_LOW:  cfg_r.speed_low  <= $signed(cfg_wdata);
        CFG_SPEED_HIGH: cfg_r.speed_high <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt_r <= in_target_speed;
    end
  end

  slmc_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (in_vld_r),
    .up_target (tgt_r),
    .up_ready  (rmp_ready),
    .dn_valid  (rmp_valid),
    .dn_data   (rmp_data),
    .dn_ready  (map_ready)
  );

  slmc_map u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .up_valid      (rmp_valid),
    .up_data       (rmp_data),
    .up_ready      (map_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_speed_now (out_speed_now),
    .out_angle     (out_angle),
    .out_at_target (out_at_target)
  );

endmodule

### rtl/core/slmc_ramp.sv
module slmc_ramp
  import slmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  slmc_cfg_t         cfg,
  input  logic              up_valid,
  input  logic signed [7:0] up_target,
  output logic              up_ready,
  output logic              dn_valid,
  output slmc_spd_t         dn_data,
  input  logic              dn_ready
);

  logic              vld_r;
  logic              vld_nxt;
  slmc_spd_t         res_r;
  logic signed [7:0] cur_r;
  logic signed [7:0] cur_nxt;
  logic signed [7:0] held_r;
  logic signed [7:0] held_nxt;
  logic signed [7:0] req_sat;
  logic              in_win;
  logic signed [8:0] diff;
  logic signed [8:0] step;
  logic signed [8:0] cur_dlt;
  logic              fire;

  assign up_ready = !vld_r || dn_ready;
  assign fire     = up_valid && up_ready;
  assign dn_valid = vld_r;
  assign dn_data  = res_r;

  always_comb begin
    in_win = (up_target >= cfg.speed_low) && (up_target <= cfg.speed_high);
    if (up_target > FULL_SPEED) begin
      req_sat = FULL_SPEED;
    end else if (up_target < -FULL_SPEED) begin
      req_sat = -FULL_SPEED;
    end else begin
      req_sat = up_target;
    end
    held_nxt = in_win ? req_sat : held_r;
    diff     = {held_nxt[7], held_nxt} - {cur_r[7], cur_r};
    step     = $signed({2'b00, cfg.accel_step});
    if (diff > step) begin
      cur_dlt = step;
    end else if (diff < -step) begin
      cur_dlt = -step;
    end else begin
      cur_dlt = diff;
    end
    cur_nxt = 8'({cur_r[7], cur_r} + cur_dlt);
    vld_nxt = up_ready ? up_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      cur_r  <= '0;
      held_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      if (fire) begin
        cur_r  <= cur_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r.speed     <= cur_nxt;
      res_r.at_target <= (cur_nxt == held_nxt);
    end
  end

  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r <= FULL_SPEED) && (cur_r >= -FULL_SPEED) &&
    (held_r <= FULL_SPEED) && (held_r >= -FULL_SPEED))
    else $error("ramp state out of full-speed range");

  a_slew_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (cur_dlt <= step) && (cur_dlt >= -step))
    else $error("speed change exceeds accel step");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cur_r) && $stable(held_r))
    else $error("ramp state moved without a transfer");

  a_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && res_r.at_target) |-> (res_r.speed == held_r))
    else $error("at_target flag disagrees with held target");

endmodule

### rtl/core/slmc_map.sv
module slmc_map
  import slmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  slmc_cfg_t         cfg,
  input  logic              up_valid,
  input  slmc_spd_t         up_data,
  output logic              up_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] out_speed_now,
  output logic [7:0]        out_angle,
  output logic              out_at_target
);

  logic               prd_vld_r;
  logic signed [15:0] prod_r;
  slmc_spd_t          prd_spd_r;
  logic               out_vld_r;
  logic signed [7:0]  spd_out_r;
  logic [7:0]         ang_out_r;
  logic               at_out_r;

  logic               out_en;
  logic               prd_en;
  logic               neg;
  logic [7:0]         mag;
  logic signed [8:0]  span;
  logic signed [16:0] prod_full;
  logic               pneg;
  logic [14:0]        pabs;
  logic [14:0]        num;
  logic [27:0]        recip_prod;
  logic [8:0]         quo;
  logic signed [10:0] ang_sum;
  logic [7:0]         ang_sat;

  assign out_en   = !out_vld_r || out_ready;
  assign prd_en   = !prd_vld_r || out_en;
  assign up_ready = prd_en;

  always_comb begin
    neg       = up_data.speed < 0;
    mag       = 8'(neg ? -up_data.speed : up_data.speed);
    span      = neg ? ($signed({1'b0, cfg.min_angle}) - $signed({1'b0, cfg.stop_angle}))
                    : ($signed({1'b0, cfg.max_angle}) - $signed({1'b0, cfg.stop_angle}));
    prod_full = {9'd0, mag} * {{8{span[8]}}, span};
  end

  always_comb begin
    pneg       = prod_r < 0;
    pabs       = 15'(pneg ? -prod_r : prod_r);
    num        = pneg ? pabs + DIV_CEIL_ADJ : pabs;
    recip_prod = {13'd0, num} * {15'd0, DIV_RECIP};
    quo        = recip_prod[DIV_SHIFT +: 9];
    ang_sum    = $signed({3'b000, cfg.stop_angle})
               + (pneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
    if (ang_sum < 0) begin
      ang_sat = 8'd0;
    end else if (ang_sum > 11'sd255) begin
      ang_sat = 8'd255;
    end else begin
      ang_sat = ang_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (prd_en) begin
        prd_vld_r <= up_valid;
      end
      if (out_en) begin
        out_vld_r <= prd_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prd_en && up_valid) begin
      prod_r    <= 16'(prod_full);
      prd_spd_r <= up_data;
    end
    if (out_en && prd_vld_r) begin
      spd_out_r <= prd_spd_r.speed;
      ang_out_r <= ang_sat;
      at_out_r  <= prd_spd_r.at_target;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_speed_now = spd_out_r;
  assign out_angle     = ang_out_r;
  assign out_at_target = at_out_r;

endmodule
